/* hdl/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP cache and responder
// Item layouts, code points and the control bundles between the top level
// and the cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // request types
    localparam logic [1:0] REQ_RX_ARP = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_SEND   = 2'd2;
    localparam logic [1:0] REQ_SPARE  = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_CONSUMED = 3'd0;
    localparam logic [2:0] KIND_REPLY    = 3'd1;
    localparam logic [2:0] KIND_REQUEST  = 3'd2;
    localparam logic [2:0] KIND_HIT      = 3'd3;
    localparam logic [2:0] KIND_MISS     = 3'd4;
    localparam logic [2:0] KIND_DROPPED  = 3'd5;

    // ARP header values
    localparam logic [15:0] HW_ETHERNET  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [15:0] OP_REQUEST   = 16'h0001;
    localparam logic [15:0] OP_REPLY     = 16'h0002;
    localparam logic [1:0]  TX_OP_REQ    = 2'd1;
    localparam logic [1:0]  TX_OP_REPLY  = 2'd2;
    localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic CFG_LOCAL_IP  = 1'b0;
    localparam logic CFG_LOCAL_MAC = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] arp_opcode;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [47:0] tx_eth_dest;
        logic [1:0]  tx_opcode;
        logic [47:0] tx_sender_mac;
        logic [31:0] tx_sender_ip;
        logic [47:0] tx_target_mac;
        logic [31:0] tx_target_ip;
        logic [47:0] found_mac;
        logic        table_full;
    } t_rsp;

    // search command to the table
    typedef struct packed {
        logic        start;
        logic [31:0] key;
    } t_tbl_cmd;

    // entry write to the table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [31:0]      ip;
        logic [47:0]      mac;
    } t_tbl_wr;

    // search outcome, valid for one cycle with done
    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_tbl_res;

endpackage

`default_nettype wire

/* hdl/arpc_req_if.sv */
// ----------------------------------------------------------------------------
// arpc_req_if: request channel of the ARP cache and responder
// Valid/ready handshake with one request item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] query_ip;

    modport source (
        output valid, req_type, hw_type, proto_type, arp_opcode,
               sender_ip, sender_mac, target_ip, query_ip,
        input  ready
    );
    modport sink (
        input  valid, req_type, hw_type, proto_type, arp_opcode,
               sender_ip, sender_mac, target_ip, query_ip,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/arpc_rsp_if.sv */
// ----------------------------------------------------------------------------
// arpc_rsp_if: result channel of the ARP cache and responder
// Valid/ready handshake with one result item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [47:0] tx_eth_dest;
    logic [1:0]  tx_opcode;
    logic [47:0] tx_sender_mac;
    logic [31:0] tx_sender_ip;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_target_ip;
    logic [47:0] found_mac;
    logic        table_full;

    modport source (
        output valid, result_kind, tx_eth_dest, tx_opcode, tx_sender_mac,
               tx_sender_ip, tx_target_mac, tx_target_ip, found_mac, table_full,
        input  ready
    );
    modport sink (
        input  valid, result_kind, tx_eth_dest, tx_opcode, tx_sender_mac,
               tx_sender_ip, tx_target_mac, tx_target_ip, found_mac, table_full,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/arp_cache_and_responder_core.sv */
// ----------------------------------------------------------------------------
// arp_cache_and_responder_core: ARP responder with an append-only IP cache
// Classifies received ARP packets, learns sender pairs, answers requests for
// the local address, serves lookups and builds broadcast requests.
// Without a cache search the request beat is registered and its result is built
//   in S_EMIT into the output register; with one, S_SEARCH waits for the table,
//   which compares one entry per cycle with its single comparator.
// One item is handled at a time: the next item is taken once the result is in
//   the output register, which holds it while the result side stalls.
// Reset clears the entry count and the local address registers; no clearing
//   pass is needed, as entries at or above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_and_responder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    arpc_req_if.sink         i_req,
    arpc_rsp_if.source       o_rsp
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

    t_state           r_state,     n_state;
    t_item            r_item,      n_item;
    logic             r_found,     n_found;
    logic [47:0]      r_fmac,      n_fmac;
    logic             r_full,      n_full;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [31:0]      r_local_ip,  n_local_ip;
    logic [47:0]      r_local_mac, n_local_mac;
    logic             r_out_vld,   n_out_vld;
    t_rsp             r_out,       n_out;

    t_item    item_in;
    t_tbl_cmd tbl_cmd;
    t_tbl_wr  tbl_wr;
    t_tbl_res tbl_res;
    logic [47:0] tbl_mac;
    t_rsp     rsp;
    logic     in_ok;
    logic     item_ok;

    arpc_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .i_wr    (tbl_wr),
        .i_count (r_count),
        .o_res   (tbl_res),
        .o_mac   (tbl_mac)
    );

    always_comb begin
        item_in.req_type   = i_req.req_type;
        item_in.hw_type    = i_req.hw_type;
        item_in.proto_type = i_req.proto_type;
        item_in.arp_opcode = i_req.arp_opcode;
        item_in.sender_ip  = i_req.sender_ip;
        item_in.sender_mac = i_req.sender_mac;
        item_in.target_ip  = i_req.target_ip;
        item_in.query_ip   = i_req.query_ip;
    end

    assign in_ok   = (item_in.hw_type == HW_ETHERNET) && (item_in.proto_type == PROTO_IPV4);
    assign item_ok = (r_item.hw_type == HW_ETHERNET) && (r_item.proto_type == PROTO_IPV4);

    // result of the held item
    always_comb begin
        rsp = '0;
        rsp.result_kind = KIND_CONSUMED;
        case (r_item.req_type)
            REQ_RX_ARP: begin
                if (!item_ok) begin
                    rsp.result_kind = KIND_DROPPED;
                end else begin
                    rsp.table_full = r_full;
                    if (r_item.arp_opcode == OP_REQUEST && r_item.target_ip == r_local_ip) begin
                        rsp.result_kind   = KIND_REPLY;
                        rsp.tx_eth_dest   = r_item.sender_mac;
                        rsp.tx_opcode     = TX_OP_REPLY;
                        rsp.tx_sender_mac = r_local_mac;
                        rsp.tx_sender_ip  = r_item.target_ip;
                        rsp.tx_target_mac = r_item.sender_mac;
                        rsp.tx_target_ip  = r_item.sender_ip;
                    end
                end
            end
            REQ_LOOKUP: begin
                if (r_item.query_ip == r_local_ip) begin
                    rsp.result_kind = KIND_HIT;
                    rsp.found_mac   = r_local_mac;
                end else if (r_found) begin
                    rsp.result_kind = KIND_HIT;
                    rsp.found_mac   = r_fmac;
                end else begin
                    rsp.result_kind = KIND_MISS;
                end
            end
            REQ_SEND: begin
                rsp.result_kind   = KIND_REQUEST;
                rsp.tx_eth_dest   = MAC_BCAST;
                rsp.tx_opcode     = TX_OP_REQ;
                rsp.tx_sender_mac = r_local_mac;
                rsp.tx_sender_ip  = r_local_ip;
                rsp.tx_target_ip  = r_item.query_ip;
            end
            default: begin
                rsp.result_kind = KIND_CONSUMED;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_found     = r_found;
        n_fmac      = r_fmac;
        n_full      = r_full;
        n_count     = r_count;
        n_local_ip  = r_local_ip;
        n_local_mac = r_local_mac;
        n_out_vld   = r_out_vld && !o_rsp.ready;
        n_out       = r_out;
        tbl_cmd     = '0;
        tbl_wr      = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOCAL_IP:  n_local_ip  = i_cfg_data[31:0];
                CFG_LOCAL_MAC: n_local_mac = i_cfg_data;
                default:       n_local_ip  = r_local_ip;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_item  = item_in;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    tbl_cmd.key = (item_in.req_type == REQ_LOOKUP) ?
                                  item_in.query_ip : item_in.sender_ip;
                    // the local pair never enters the table: skip its search
                    if ((item_in.req_type == REQ_RX_ARP && in_ok &&
                         item_in.sender_ip != r_local_ip) ||
                        (item_in.req_type == REQ_LOOKUP &&
                         item_in.query_ip != r_local_ip)) begin
                        tbl_cmd.start = 1'b1;
                        n_state       = S_SEARCH;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SEARCH: begin
                if (tbl_res.done) begin
                    n_found = tbl_res.found;
                    n_fmac  = tbl_mac;
                    if (r_item.req_type == REQ_RX_ARP) begin
                        tbl_wr.ip  = r_item.sender_ip;
                        tbl_wr.mac = r_item.sender_mac;
                        if (tbl_res.found) begin
                            tbl_wr.en  = 1'b1;
                            tbl_wr.idx = tbl_res.idx;
                        end else if (r_count < DEPTH_CNT) begin
                            // append at the first free slot
                            tbl_wr.en  = 1'b1;
                            tbl_wr.idx = r_count[IDX_W-1:0];
                            n_count    = r_count + CNT_W'(1);
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_vld || o_rsp.ready) begin
                    n_out     = rsp;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_local_ip  <= '0;
            r_local_mac <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_local_ip  <= n_local_ip;
            r_local_mac <= n_local_mac;
            r_out_vld   <= n_out_vld;
        end
        r_item  <= n_item;
        r_found <= n_found;
        r_fmac  <= n_fmac;
        r_full  <= n_full;
        r_out   <= n_out;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.result_kind   = r_out.result_kind;
    assign o_rsp.tx_eth_dest   = r_out.tx_eth_dest;
    assign o_rsp.tx_opcode     = r_out.tx_opcode;
    assign o_rsp.tx_sender_mac = r_out.tx_sender_mac;
    assign o_rsp.tx_sender_ip  = r_out.tx_sender_ip;
    assign o_rsp.tx_target_mac = r_out.tx_target_mac;
    assign o_rsp.tx_target_ip  = r_out.tx_target_ip;
    assign o_rsp.found_mac     = r_out.found_mac;
    assign o_rsp.table_full    = r_out.table_full;

endmodule

`default_nettype wire

/* hdl/arpc_table.sv */
// ----------------------------------------------------------------------------
// arpc_table: IP-to-MAC cache memory with a sequential search unit
// One entry is read per cycle and compared against the key by a single
// comparator; the search stops at the first match or after the last entry.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire arpc_pkg::t_tbl_cmd i_cmd,
    input  wire arpc_pkg::t_tbl_wr  i_wr,
    input  wire logic [arpc_pkg::CNT_W-1:0] i_count,
    output arpc_pkg::t_tbl_res      o_res,
    output logic [47:0]             o_mac
);
    import arpc_pkg::*;

    logic [31:0] r_mem_ip  [DEPTH];
    logic [47:0] r_mem_mac [DEPTH];

    logic             r_busy;
    logic [CNT_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic [31:0]      r_key;
    logic [31:0]      r_rd_ip;
    logic [47:0]      r_rd_mac;

    logic more;
    logic hit;
    logic issue;
    logic done;

    assign more  = (r_addr < i_count);
    assign hit   = r_rd_vld && (r_rd_ip == r_key);
    assign issue = r_busy && !hit && more;
    assign done  = r_busy && (hit || (!r_rd_vld && !more));

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_ip[i_wr.idx]  <= i_wr.ip;
            r_mem_mac[i_wr.idx] <= i_wr.mac;
        end
        r_rd_ip  <= r_mem_ip[r_addr[IDX_W-1:0]];
        r_rd_mac <= r_mem_mac[r_addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_rd_idx <= '0;
            r_key    <= '0;
        end else if (i_cmd.start) begin
            r_busy   <= 1'b1;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_key    <= i_cmd.key;
        end else begin
            r_rd_vld <= issue;
            if (issue) begin
                r_rd_idx <= r_addr[IDX_W-1:0];
                r_addr   <= r_addr + CNT_W'(1);
            end
            if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        o_res.done  = done;
        o_res.found = hit;
        o_res.idx   = r_rd_idx;
    end

    assign o_mac = r_rd_mac;

endmodule

`default_nettype wire

/* test/arp_cache_and_responder_core_checker.sv */
// ----------------------------------------------------------------------------
// arp_cache_and_responder_core_checker: result checker for the ARP core
// Watches the configuration port and both channels, keeps its own copy of
// the local address and the cache, predicts one result per request beat and
// compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_and_responder_core_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    arpc_req_if              i_req,
    arpc_rsp_if              i_rsp,
    output int               o_fail_count,
    output int               o_pending
);
    import arpc_pkg::*;

    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic [31:0] cache_ip  [DEPTH];
    logic [47:0] cache_mac [DEPTH];
    int          cache_count;

    t_rsp        rsp_q[$];
    int          reported;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        reported     = 0;
        own_ip       = '0;
        own_mac      = '0;
        cache_count  = 0;
    end

    function automatic int cache_find(input logic [31:0] ip);
        for (int k = 0; k < cache_count; k++) begin
            if (cache_ip[k] == ip) return k;
        end
        return -1;
    endfunction

    // returns 1 when the pair is lost because every slot is taken
    function automatic logic cache_learn(input logic [31:0] ip, input logic [47:0] mac);
        int slot;
        if (ip == own_ip) return 1'b0;
        slot = cache_find(ip);
        if (slot >= 0) begin
            cache_mac[slot] = mac;
            return 1'b0;
        end
        if (cache_count >= DEPTH) return 1'b1;
        cache_ip[cache_count]  = ip;
        cache_mac[cache_count] = mac;
        cache_count++;
        return 1'b0;
    endfunction

    function automatic t_rsp arp_outcome(input t_item it);
        t_rsp r;
        int   slot;
        r = '0;
        r.result_kind = KIND_CONSUMED;
        case (it.req_type)
            REQ_RX_ARP: begin
                if (it.hw_type != HW_ETHERNET || it.proto_type != PROTO_IPV4) begin
                    r.result_kind = KIND_DROPPED;
                end else begin
                    r.table_full = cache_learn(it.sender_ip, it.sender_mac);
                    if (it.arp_opcode == OP_REQUEST && it.target_ip == own_ip) begin
                        r.result_kind   = KIND_REPLY;
                        r.tx_eth_dest   = it.sender_mac;
                        r.tx_opcode     = TX_OP_REPLY;
                        r.tx_sender_mac = own_mac;
                        r.tx_sender_ip  = it.target_ip;
                        r.tx_target_mac = it.sender_mac;
                        r.tx_target_ip  = it.sender_ip;
                    end
                end
            end
            REQ_LOOKUP: begin
                // the local pair shadows any cached entry with the same address
                if (it.query_ip == own_ip) begin
                    r.result_kind = KIND_HIT;
                    r.found_mac   = own_mac;
                end else begin
                    slot = cache_find(it.query_ip);
                    if (slot >= 0) begin
                        r.result_kind = KIND_HIT;
                        r.found_mac   = cache_mac[slot];
                    end else begin
                        r.result_kind = KIND_MISS;
                    end
                end
            end
            REQ_SEND: begin
                r.result_kind   = KIND_REQUEST;
                r.tx_eth_dest   = MAC_BCAST;
                r.tx_opcode     = TX_OP_REQ;
                r.tx_sender_mac = own_mac;
                r.tx_sender_ip  = own_ip;
                r.tx_target_ip  = it.query_ip;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [47:0] want,
                               input logic [47:0] got, inout bit bad);
        if (got !== want) begin
            bad = 1'b1;
            if (reported < 10) begin
                $display("mismatch in %s: expected %h, got %h", fname, want, got);
                reported++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_item beat_in;
        t_rsp  want;
        bit    bad;
        if (!i_rst_n) begin
            own_ip      = '0;
            own_mac     = '0;
            cache_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LOCAL_IP) own_ip = i_cfg_data[31:0];
                else                           own_mac = i_cfg_data;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_q.size() == 0) begin
                    o_fail_count++;
                    if (reported < 10) begin
                        $display("result beat with nothing expected, kind %0d",
                                 i_rsp.result_kind);
                        reported++;
                    end
                end else begin
                    want = rsp_q.pop_front();
                    bad  = 1'b0;
                    check_field("result_kind", 48'(want.result_kind),
                                48'(i_rsp.result_kind), bad);
                    check_field("tx_eth_dest", want.tx_eth_dest, i_rsp.tx_eth_dest, bad);
                    check_field("tx_opcode", 48'(want.tx_opcode), 48'(i_rsp.tx_opcode),
                                bad);
                    check_field("tx_sender_mac", want.tx_sender_mac, i_rsp.tx_sender_mac,
                                bad);
                    check_field("tx_sender_ip", 48'(want.tx_sender_ip),
                                48'(i_rsp.tx_sender_ip), bad);
                    check_field("tx_target_mac", want.tx_target_mac, i_rsp.tx_target_mac,
                                bad);
                    check_field("tx_target_ip", 48'(want.tx_target_ip),
                                48'(i_rsp.tx_target_ip), bad);
                    check_field("found_mac", want.found_mac, i_rsp.found_mac, bad);
                    check_field("table_full", 48'(want.table_full),
                                48'(i_rsp.table_full), bad);
                    if (bad) o_fail_count++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                beat_in.req_type   = i_req.req_type;
                beat_in.hw_type    = i_req.hw_type;
                beat_in.proto_type = i_req.proto_type;
                beat_in.arp_opcode = i_req.arp_opcode;
                beat_in.sender_ip  = i_req.sender_ip;
                beat_in.sender_mac = i_req.sender_mac;
                beat_in.target_ip  = i_req.target_ip;
                beat_in.query_ip   = i_req.query_ip;
                rsp_q = {rsp_q, arp_outcome(beat_in)};
            end
        end
        o_pending = rsp_q.size();
    end

endmodule

`default_nettype wire

/* test/arp_cache_and_responder_core_tb.sv */
// ----------------------------------------------------------------------------
// arp_cache_and_responder_core_tb: testbench top of the ARP core
// Drives directed ARP traffic, then random phases under several local address
// settings with random gaps on both channels; the checker module predicts
// and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_and_responder_core_tb;
    import arpc_pkg::*;

    localparam int SETTLE     = DEPTH + 8;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 340;
    localparam int POOL_SIZE  = 24;
    localparam int CYCLE_CAP  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [47:0] i_cfg_data;

    arpc_req_if arp_req ();
    arpc_rsp_if arp_rsp ();

    int          fail_count;
    int          pending;
    int          cycles;
    bit          calm;
    logic [31:0] cur_ip;
    logic [31:0] ip_pool [POOL_SIZE];

    arp_cache_and_responder_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (arp_req),
        .o_rsp      (arp_rsp)
    );

    arp_cache_and_responder_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (arp_req),
        .i_rsp        (arp_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("arp_cache_and_responder_core_tb NOT OK");
            $finish;
        end
    end

    // result side: random stall before each beat
    initial begin
        int gap;
        arp_rsp.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                arp_rsp.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            arp_rsp.ready <= 1'b1;
            @(posedge i_clk);
            while (!(arp_rsp.valid && arp_rsp.ready)) @(posedge i_clk);
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [31:0] pick_ip();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return $urandom;
        if (sel == 1) return cur_ip;
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_item rx_item(input logic [15:0] hw, input logic [15:0] proto,
                                      input logic [15:0] op, input logic [31:0] sip,
                                      input logic [47:0] smac, input logic [31:0] tip);
        t_item it;
        it.req_type   = REQ_RX_ARP;
        it.hw_type    = hw;
        it.proto_type = proto;
        it.arp_opcode = op;
        it.sender_ip  = sip;
        it.sender_mac = smac;
        it.target_ip  = tip;
        it.query_ip   = $urandom;
        return it;
    endfunction

    function automatic t_item query_item(input logic [1:0] req, input logic [31:0] qip);
        t_item it;
        it.req_type   = req;
        it.hw_type    = 16'($urandom);
        it.proto_type = 16'($urandom);
        it.arp_opcode = 16'($urandom);
        it.sender_ip  = $urandom;
        it.sender_mac = rand48();
        it.target_ip  = $urandom;
        it.query_ip   = qip;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item       it;
        int          sel;
        logic [15:0] hw;
        logic [15:0] proto;
        logic [15:0] op;
        sel = $urandom_range(0, 15);
        if (sel <= 8) begin
            hw    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : HW_ETHERNET;
            proto = ($urandom_range(0, 9) == 0) ? 16'($urandom) : PROTO_IPV4;
            case ($urandom_range(0, 3))
                0:       op = 16'($urandom);
                3:       op = OP_REPLY;
                default: op = OP_REQUEST;
            endcase
            it = rx_item(hw, proto, op, pick_ip(), rand48(),
                         $urandom_range(0, 1) ? cur_ip : pick_ip());
        end else if (sel <= 11) begin
            it = query_item(REQ_LOOKUP, pick_ip());
        end else if (sel <= 13) begin
            it = query_item(REQ_SEND, pick_ip());
        end else if (sel == 14) begin
            it = query_item(REQ_SPARE, pick_ip());
        end else begin
            // noise: every field random
            it = query_item(2'($urandom), $urandom);
        end
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input t_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            arp_req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        arp_req.req_type   <= it.req_type;
        arp_req.hw_type    <= it.hw_type;
        arp_req.proto_type <= it.proto_type;
        arp_req.arp_opcode <= it.arp_opcode;
        arp_req.sender_ip  <= it.sender_ip;
        arp_req.sender_mac <= it.sender_mac;
        arp_req.target_ip  <= it.target_ip;
        arp_req.query_ip   <= it.query_ip;
        arp_req.valid      <= 1'b1;
        @(posedge i_clk);
        while (!(arp_req.valid && arp_req.ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain(input int extra);
        arp_req.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_local(input logic [31:0] ip, input logic [47:0] mac);
        write_reg(CFG_LOCAL_IP, {16'h0, ip});
        write_reg(CFG_LOCAL_MAC, mac);
        cur_ip = ip;
    endtask

    initial begin
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        logic [31:0] new_ip;
        logic [47:0] new_mac;
        cycles     = 0;
        calm       = 1'b0;
        cur_ip     = '0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LOCAL_IP;
        i_cfg_data = '0;
        arp_req.valid      = 1'b0;
        arp_req.req_type   = REQ_RX_ARP;
        arp_req.hw_type    = '0;
        arp_req.proto_type = '0;
        arp_req.arp_opcode = '0;
        arp_req.sender_ip  = '0;
        arp_req.sender_mac = '0;
        arp_req.target_ip  = '0;
        arp_req.query_ip   = '0;

        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        ip_pool[2] = 32'hC0A8_0001;
        for (int k = 3; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
        ip_a = ip_pool[3];
        ip_b = ip_pool[4];

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_local(32'hC0A8_0001, 48'h0200_0000_0001);

        // directed: malformed packets are dropped
        send_item(rx_item(16'd2, PROTO_IPV4, OP_REQUEST, ip_a, rand48(), cur_ip));
        send_item(rx_item(HW_ETHERNET, 16'h86DD, OP_REQUEST, ip_a, rand48(), cur_ip));
        send_item(rx_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1, '1));
        // request for us: reply and learn
        send_item(rx_item(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, ip_a, '1, cur_ip));
        // request for someone else: learn only
        send_item(rx_item(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, ip_b, '0, ip_a));
        // reply and unknown opcodes update the existing pairs
        send_item(rx_item(HW_ETHERNET, PROTO_IPV4, OP_REPLY, ip_a, 48'h1234_5678_9ABC,
                          cur_ip));
        send_item(rx_item(HW_ETHERNET, PROTO_IPV4, 16'hFFFF, ip_b, 48'hA5A5_5A5A_0F0F,
                          cur_ip));
        // own address offered by a peer: not stored
        send_item(rx_item(HW_ETHERNET, PROTO_IPV4, 16'd0, cur_ip, 48'hDEAD_BEEF_0001, ip_a));
        send_item(rx_item(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 32'h0, rand48(), ip_b));
        send_item(rx_item(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 32'hFFFF_FFFF, rand48(),
                          32'hFFFF_FFFF));
        send_item(query_item(REQ_LOOKUP, cur_ip));
        send_item(query_item(REQ_LOOKUP, ip_a));
        send_item(query_item(REQ_LOOKUP, ip_b));
        send_item(query_item(REQ_LOOKUP, 32'h0));
        send_item(query_item(REQ_LOOKUP, 32'hFFFF_FFFF));
        send_item(query_item(REQ_LOOKUP, ip_pool[5]));
        send_item(query_item(REQ_SEND, 32'h0));
        send_item(query_item(REQ_SEND, 32'hFFFF_FFFF));
        send_item(query_item(REQ_SPARE, 32'hFFFF_FFFF));
        send_item(query_item(REQ_SPARE, 32'h0));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain(SETTLE);
            case (ph)
                0:       begin new_ip = 32'h0;          new_mac = 48'h0; end
                1:       begin new_ip = 32'hFFFF_FFFF;  new_mac = '1;    end
                2:       begin new_ip = ip_pool[$urandom_range(3, POOL_SIZE - 1)];
                               new_mac = rand48(); end
                3:       begin new_ip = $urandom;       new_mac = rand48(); end
                4:       begin new_ip = ip_a;           new_mac = 48'h0; end
                default: begin new_ip = 32'hFFFF_FFFF;  new_mac = rand48(); end
            endcase
            set_local(new_ip, new_mac);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
                // now and then hold the sender until the results are all in
                if ($urandom_range(0, 99) == 0) drain(0);
                send_item(random_item());
            end
        end

        drain(SETTLE);
        if (fail_count == 0) begin
            $display("arp_cache_and_responder_core_tb OK");
        end else begin
            $display("arp_cache_and_responder_core_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
